/* rtl/core/slt_pkg.sv */
// Shared types, token codes and keyword table for the script lexer tokenizer.
// No dependencies; compiled first.
package slt_pkg;

  localparam int POS_BITS      = 16;
  localparam int KEYWORD_BYTES = 6;
  localparam int OUT_W         = 16;
  localparam int KIND_W        = 6;
  localparam int ERR_W         = 2;
  localparam int ID_LEN_W      = $clog2(KEYWORD_BYTES + 2);
  localparam int SAT_W         = (POS_BITS + 1 > OUT_W + 1) ? POS_BITS + 1 : OUT_W + 1;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);
  localparam int NUM_KW        = 11;
  localparam int KW_MAX_LEN    = 6;

  localparam logic [POS_BITS-1:0] POS_MAX  = {POS_BITS{1'b1}};
  localparam logic [OUT_W-1:0]    LINE_MAX = {OUT_W{1'b1}};

  localparam logic [KIND_W-1:0] K_END   = 6'd0;
  localparam logic [KIND_W-1:0] K_PUNCT_LAST = 6'd15;
  localparam logic [KIND_W-1:0] K_NOT   = 6'd16;
  localparam logic [KIND_W-1:0] K_LESS  = 6'd18;
  localparam logic [KIND_W-1:0] K_MORE  = 6'd20;
  localparam logic [KIND_W-1:0] K_BIND  = 6'd22;
  localparam logic [KIND_W-1:0] K_STR   = 6'd23;
  localparam logic [KIND_W-1:0] K_ID    = 6'd24;
  localparam logic [KIND_W-1:0] K_NB    = 6'd25;
  localparam logic [KIND_W-1:0] K_ERR   = 6'd37;

  localparam logic [ERR_W-1:0] E_NONE   = 2'd0;
  localparam logic [ERR_W-1:0] E_COLON  = 2'd1;
  localparam logic [ERR_W-1:0] E_STRING = 2'd2;
  localparam logic [ERR_W-1:0] E_CHAR   = 2'd3;

  localparam logic [7:0] C_NUL   = 8'h00;
  localparam logic [7:0] C_LF    = 8'h0A;
  localparam logic [7:0] C_HASH  = "#";
  localparam logic [7:0] C_QUOTE = 8'h22;
  localparam logic [7:0] C_DOT   = ".";
  localparam logic [7:0] C_EQ    = "=";
  localparam logic [7:0] C_COLON = ":";
  localparam logic [7:0] C_BANG  = "!";
  localparam logic [7:0] C_LT    = "<";
  localparam logic [7:0] C_GT    = ">";

  typedef enum logic [3:0] {
    M_IDLE    = 4'd0,
    M_COMMENT = 4'd1,
    M_STRING  = 4'd2,
    M_IDENT   = 4'd3,
    M_INT     = 4'd4,
    M_FRAC    = 4'd5,
    M_OP2     = 4'd6
  } lex_mode_t;

  typedef logic [KEYWORD_BYTES-1:0][7:0] ident_bytes_t;

  typedef struct packed {
    logic [2:0]                 len;
    logic [KW_MAX_LEN-1:0][7:0] text;
    logic [KIND_W-1:0]          kind;
  } kw_t;

  localparam kw_t KW_TABLE [NUM_KW] = '{
    '{3'd4, {8'd0, 8'd0, "e", "s", "l", "e"}, 6'd26},
    '{3'd4, {8'd0, 8'd0, "c", "n", "u", "f"}, 6'd27},
    '{3'd5, {8'd0, "e", "s", "l", "a", "f"},  6'd28},
    '{3'd3, {8'd0, 8'd0, 8'd0, "r", "o", "f"}, 6'd29},
    '{3'd2, {8'd0, 8'd0, 8'd0, 8'd0, "f", "i"}, 6'd30},
    '{3'd3, {8'd0, 8'd0, 8'd0, "f", "n", "i"}, 6'd31},
    '{3'd3, {8'd0, 8'd0, 8'd0, "t", "e", "l"}, 6'd32},
    '{3'd3, {8'd0, 8'd0, 8'd0, "n", "a", "n"}, 6'd33},
    '{3'd5, {8'd0, "t", "n", "i", "r", "p"},  6'd34},
    '{3'd6, {"n", "r", "u", "t", "e", "r"},   6'd35},
    '{3'd4, {8'd0, 8'd0, "e", "u", "r", "t"}, 6'd36}
  };

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [OUT_W-1:0]  tok_start;
    logic [OUT_W-1:0]  tok_length;
    logic [OUT_W-1:0]  line_no;
    logic [ERR_W-1:0]  err_code;
    logic              last;
  } tok_t;

  function automatic logic [KIND_W-1:0] kw_lookup(ident_bytes_t b,
                                                   logic [ID_LEN_W-1:0] len);
    logic [KIND_W-1:0] k;
    logic              same;
    k = K_ID;
    for (int i = NUM_KW - 1; i >= 0; i--) begin
      same = (len == ID_LEN_W'(KW_TABLE[i].len));
      for (int j = 0; j < KW_MAX_LEN; j++) begin
        if (j < int'(KW_TABLE[i].len) && b[j] != KW_TABLE[i].text[j]) begin
          same = 1'b0;
        end
      end
      if (same) begin
        k = KW_TABLE[i].kind;
      end
    end
    return k;
  endfunction

  function automatic logic [KIND_W-1:0] single_kind(logic [7:0] c);
    logic [KIND_W-1:0] k;
    case (c)
      "(":     k = 6'd1;
      ")":     k = 6'd2;
      "{":     k = 6'd3;
      "}":     k = 6'd4;
      ";":     k = 6'd5;
      ",":     k = 6'd6;
      ".":     k = 6'd7;
      "+":     k = 6'd8;
      "-":     k = 6'd9;
      "*":     k = 6'd10;
      "/":     k = 6'd11;
      "=":     k = 6'd12;
      "&":     k = 6'd13;
      "|":     k = 6'd14;
      "^":     k = 6'd15;
      default: k = K_END;
    endcase
    return k;
  endfunction

  function automatic logic [OUT_W-1:0] sat_out(logic [SAT_W-1:0] v);
    logic [OUT_W-1:0] r;
    if (v > SAT_W'(LINE_MAX)) begin
      r = LINE_MAX;
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/core/slt_if.sv */
// Valid/ready channel interfaces for source bytes and tokens.
// Depends on slt_pkg.
interface slt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

interface slt_tok_if;
  logic                      valid;
  logic                      ready;
  logic [slt_pkg::KIND_W-1:0] kind;
  logic [slt_pkg::OUT_W-1:0]  tok_start;
  logic [slt_pkg::OUT_W-1:0]  tok_length;
  logic [slt_pkg::OUT_W-1:0]  line_no;
  logic [slt_pkg::ERR_W-1:0]  err_code;
  logic                      last;

  modport source (output valid, output kind, output tok_start, output tok_length,
                  output line_no, output err_code, output last, input ready);
  modport sink (input valid, input kind, input tok_start, input tok_length,
                input line_no, input err_code, input last, output ready);
endinterface

/* rtl/core/script_lexer_tokenizer.sv */
// Top level of the script lexer tokenizer: scanner state and token queue.
// Depends on slt_pkg and the channel interfaces in slt_if.sv.
//
//   channel  | dir | payload                                          | request
//   in_byte  | in  | ch                                               | one byte
//   out_tok  | out | kind tok_start tok_length line_no err_code last  | one token
//
// A byte is scanned in the cycle it is accepted; its zero, one or two tokens are
// written into a four-entry token queue and leave it one per cycle while out_tok is ready.
// A byte is taken whenever two queue entries are free, so one byte per cycle
// is sustained while tokens are taken as fast as they are made.
// Reset (rst_n low, synchronous) returns to the idle mode, position 0, line 1
// and an empty queue. A stall on out_tok fills the queue and then holds in_byte.
module script_lexer_tokenizer (
  input  logic      clk,
  input  logic      rst_n,
  slt_byte_if.sink  in_byte,
  slt_tok_if.source out_tok
);
  import slt_pkg::*;

  lex_mode_t                 mode_r, mode_nxt;
  logic [POS_BITS-1:0]       pos_r, pos_nxt;
  logic [OUT_W-1:0]          line_r, line_nxt;
  logic [POS_BITS-1:0]       tstart_r, tstart_nxt;
  logic [KIND_W-1:0]         pend_r, pend_nxt;
  ident_bytes_t              idb_r, idb_nxt;
  logic [ID_LEN_W-1:0]       idlen_r, idlen_nxt;

  tok_t                      fifo_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]     head_r, tail_r;
  logic [FIFO_CNT_W-1:0]     count_r;

  logic [7:0]                c;
  logic                      acc, pop;
  logic                      ch_alpha, ch_digit, ch_space, is_op2;
  logic [KIND_W-1:0]         sk;
  logic                      consumed, early_end;
  logic [POS_BITS-1:0]       held;
  logic [SAT_W-1:0]          held_s, incl_s, pos_s, tstart_s;
  tok_t                      r0, r1;
  logic                      v0, v1;
  logic [1:0]                n_res;

  assign c        = in_byte.ch;
  assign acc      = in_byte.valid && in_byte.ready;
  assign pop      = out_tok.valid && out_tok.ready;
  assign in_byte.ready = (count_r <= FIFO_CNT_W'(FIFO_DEPTH - 2));

  assign ch_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  assign ch_digit = (c >= "0" && c <= "9");
  assign ch_space = (c == " ") || (c >= 8'd9 && c <= 8'd13);
  assign is_op2   = (c == C_BANG) || (c == C_LT) || (c == C_GT) || (c == C_COLON);
  assign sk       = single_kind(c);

  assign held     = pos_r - tstart_r;
  assign held_s   = SAT_W'(held);
  assign incl_s   = SAT_W'(held) + SAT_W'(1);
  assign pos_s    = SAT_W'(pos_r);
  assign tstart_s = SAT_W'(tstart_r);

  always_comb begin
    consumed  = 1'b1;
    early_end = 1'b0;
    case (mode_r)
      M_COMMENT: early_end = (c == C_NUL);
      M_STRING:  early_end = (c == C_NUL);
      M_IDENT:   consumed  = ch_alpha || ch_digit;
      M_INT:     consumed  = ch_digit || (c == C_DOT);
      M_FRAC:    consumed  = ch_digit;
      M_OP2:     consumed  = (pend_r == K_BIND) ? (c == C_COLON) : (c == C_EQ);
      default:   consumed  = 1'b0;
    endcase
  end

  always_comb begin
    mode_nxt = mode_r;
    if (acc) begin
      if (early_end) begin
        mode_nxt = M_IDLE;
      end else begin
        case (mode_r)
          M_COMMENT: if (c == C_LF) mode_nxt = M_IDLE;
          M_STRING:  if (c == C_QUOTE) mode_nxt = M_IDLE;
          M_IDENT:   if (!consumed) mode_nxt = M_IDLE;
          M_INT: begin
            if (c == C_DOT) mode_nxt = M_FRAC;
            else if (!consumed) mode_nxt = M_IDLE;
          end
          M_FRAC:    if (!consumed) mode_nxt = M_IDLE;
          default:   mode_nxt = M_IDLE;
        endcase
        if (!consumed) begin
          if (c == C_NUL || ch_space) mode_nxt = M_IDLE;
          else if (c == C_HASH) mode_nxt = M_COMMENT;
          else if (sk != K_END) mode_nxt = M_IDLE;
          else if (is_op2) mode_nxt = M_OP2;
          else if (c == C_QUOTE) mode_nxt = M_STRING;
          else if (ch_alpha) mode_nxt = M_IDENT;
          else if (ch_digit) mode_nxt = M_INT;
          else mode_nxt = M_IDLE;
        end
      end
    end
  end

  always_comb begin
    tok_t e;
    logic ev;
    logic restart;
    pos_nxt    = pos_r;
    line_nxt   = line_r;
    tstart_nxt = tstart_r;
    pend_nxt   = pend_r;
    idb_nxt    = idb_r;
    idlen_nxt  = idlen_r;
    restart    = 1'b0;
    v0         = 1'b0;
    v1         = 1'b0;
    r0         = '0;
    r0.line_no = line_r;
    r1         = r0;
    e          = r0;
    ev         = 1'b0;
    if (acc) begin
      case (mode_r)
        M_COMMENT: begin
          if (early_end) begin
            v0 = 1'b1;
            r0.kind = K_END;
            r0.tok_start = sat_out(pos_s);
            restart = 1'b1;
          end else if (c == C_LF && line_r != LINE_MAX) begin
            line_nxt = line_r + OUT_W'(1);
          end
        end
        M_STRING: begin
          if (early_end) begin
            v0 = 1'b1;
            r0.kind = K_ERR;
            r0.tok_start = sat_out(tstart_s);
            r0.tok_length = sat_out(held_s);
            r0.err_code = E_STRING;
            v1 = 1'b1;
            r1.kind = K_END;
            r1.tok_start = sat_out(pos_s);
            restart = 1'b1;
          end else if (c == C_QUOTE) begin
            v0 = 1'b1;
            r0.kind = K_STR;
            r0.tok_start = sat_out(tstart_s);
            r0.tok_length = sat_out(incl_s);
          end else if (c == C_LF && line_r != LINE_MAX) begin
            line_nxt = line_r + OUT_W'(1);
          end
        end
        M_IDENT: begin
          if (consumed) begin
            for (int i = 0; i < KEYWORD_BYTES; i++) begin
              if (idlen_r == ID_LEN_W'(i)) idb_nxt[i] = c;
            end
            if (idlen_r <= ID_LEN_W'(KEYWORD_BYTES)) idlen_nxt = idlen_r + ID_LEN_W'(1);
          end else begin
            v0 = 1'b1;
            r0.kind = kw_lookup(idb_r, idlen_r);
            r0.tok_start = sat_out(tstart_s);
            r0.tok_length = sat_out(held_s);
          end
        end
        M_INT, M_FRAC: begin
          if (!consumed) begin
            v0 = 1'b1;
            r0.kind = K_NB;
            r0.tok_start = sat_out(tstart_s);
            r0.tok_length = sat_out(held_s);
          end
        end
        M_OP2: begin
          v0 = 1'b1;
          r0.tok_start = sat_out(tstart_s);
          if (pend_r == K_BIND) begin
            if (consumed) begin
              r0.kind = K_BIND;
              r0.tok_length = sat_out(incl_s);
            end else begin
              r0.kind = K_ERR;
              r0.tok_length = OUT_W'(1);
              r0.err_code = E_COLON;
            end
          end else if (consumed) begin
            r0.kind = pend_r + KIND_W'(1);
            r0.tok_length = sat_out(incl_s);
          end else begin
            r0.kind = pend_r;
            r0.tok_length = sat_out(held_s);
          end
          pend_nxt = K_END;
        end
        default: ;
      endcase

      if (!consumed) begin
        if (c == C_NUL) begin
          ev = 1'b1;
          e.kind = K_END;
          e.tok_start = sat_out(pos_s);
          restart = 1'b1;
        end else if (ch_space) begin
          if (c == C_LF && line_r != LINE_MAX) line_nxt = line_r + OUT_W'(1);
        end else if (c == C_HASH) begin
        end else if (sk != K_END) begin
          ev = 1'b1;
          e.kind = sk;
          e.tok_start = sat_out(pos_s);
          e.tok_length = OUT_W'(1);
        end else if (is_op2) begin
          tstart_nxt = pos_r;
          pend_nxt = (c == C_BANG) ? K_NOT : (c == C_LT) ? K_LESS :
                     (c == C_GT) ? K_MORE : K_BIND;
        end else if (c == C_QUOTE) begin
          tstart_nxt = pos_r;
        end else if (ch_alpha) begin
          tstart_nxt = pos_r;
          idb_nxt[0] = c;
          idlen_nxt  = ID_LEN_W'(1);
        end else if (ch_digit) begin
          tstart_nxt = pos_r;
        end else begin
          ev = 1'b1;
          e.kind = K_ERR;
          e.tok_start = sat_out(pos_s);
          e.tok_length = OUT_W'(1);
          e.err_code = E_CHAR;
        end
        if (ev) begin
          if (v0) begin
            v1 = 1'b1;
            r1 = e;
          end else begin
            v0 = 1'b1;
            r0 = e;
          end
        end
      end

      if (restart) begin
        pos_nxt    = '0;
        line_nxt   = OUT_W'(1);
        tstart_nxt = '0;
        pend_nxt   = K_END;
        idlen_nxt  = '0;
      end else if (pos_r != POS_MAX) begin
        pos_nxt = pos_r + POS_BITS'(1);
      end

      if (v1) r1.last = 1'b1;
      else if (v0) r0.last = 1'b1;
    end
  end

  assign n_res = {1'b0, v0} + {1'b0, v1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      pos_r    <= '0;
      line_r   <= OUT_W'(1);
      tstart_r <= '0;
      pend_r   <= K_END;
      idlen_r  <= '0;
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
    end else begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      line_r   <= line_nxt;
      tstart_r <= tstart_nxt;
      pend_r   <= pend_nxt;
      idlen_r  <= idlen_nxt;
      head_r   <= head_r + FIFO_PTR_W'(pop);
      tail_r   <= tail_r + FIFO_PTR_W'(n_res);
      count_r  <= count_r + FIFO_CNT_W'(n_res) - FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    idb_r <= idb_nxt;
    if (v0) fifo_r[tail_r] <= r0;
    if (v1) fifo_r[tail_r + FIFO_PTR_W'(1)] <= r1;
  end

  assign out_tok.valid      = (count_r != '0);
  assign out_tok.kind       = fifo_r[head_r].kind;
  assign out_tok.tok_start  = fifo_r[head_r].tok_start;
  assign out_tok.tok_length = fifo_r[head_r].tok_length;
  assign out_tok.line_no    = fifo_r[head_r].line_no;
  assign out_tok.err_code   = fifo_r[head_r].err_code;
  assign out_tok.last       = fifo_r[head_r].last;

endmodule

/* rtl/core/slt_checker.sv */
// Port-level checks for script_lexer_tokenizer, attached by bind.
// Depends on slt_pkg.
module slt_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [slt_pkg::KIND_W-1:0] out_kind,
  input logic [slt_pkg::OUT_W-1:0]  out_tok_length,
  input logic [slt_pkg::ERR_W-1:0]  out_err_code,
  input logic                       out_last
);
  import slt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind))
    else $error("token dropped or changed while stalled");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_kind == K_ERR) == (out_err_code != E_NONE)))
    else $error("error code does not match token kind");

  a_end_tok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == K_END |-> out_last && out_tok_length == '0)
    else $error("end token not last or has nonzero length");

  a_punct_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != K_END && out_kind <= K_PUNCT_LAST |-> out_tok_length == 16'd1)
    else $error("single-character token with wrong length");

endmodule

bind script_lexer_tokenizer slt_checker u_slt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_tok.valid),
  .out_ready      (out_tok.ready),
  .out_kind       (out_tok.kind),
  .out_tok_length (out_tok.tok_length),
  .out_err_code   (out_tok.err_code),
  .out_last       (out_tok.last)
);
